[rtl/packed_dna_prefix_match_defines.svh]
// Assertion macros shared by the packed DNA prefix match design.
`ifndef PACKED_DNA_PREFIX_MATCH_DEFINES_SVH
`define PACKED_DNA_PREFIX_MATCH_DEFINES_SVH

// Same-cycle implication, sampled on i_clk and disabled while i_rst_n is low.
`define PDPM_CHECK_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("pdpm same-cycle check failed");

// Next-cycle implication, sampled on i_clk and disabled while i_rst_n is low.
`define PDPM_CHECK_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("pdpm next-cycle check failed");

`endif

[rtl/pdpm_pkg.sv]
// Shared constants, codes and the command type of the packed DNA prefix match block.
package pdpm_pkg;

    localparam int MAX_WORDS      = 2048;
    localparam int BASES_PER_WORD = 32;
    localparam int MAX_QUERY_LEN  = 31;

    localparam int WORD_W    = 64;
    localparam int BASE_W    = 2;
    localparam int OFF_W     = $clog2(BASES_PER_WORD);
    localparam int WADDR_W   = (MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1;
    localparam int MAX_BASES = MAX_WORDS * BASES_PER_WORD;
    localparam int LEN_W     = $clog2(MAX_BASES + 1);
    localparam int START_W   = 17;
    localparam int CHAR_W    = 8;
    localparam int COUNT_W   = 5;
    localparam int QLEN_W    = 5;
    localparam int GROUP_W   = 6;
    localparam int ERR_W     = 3;

    localparam logic [CHAR_W-1:0] CHAR_A = 8'h41;
    localparam logic [CHAR_W-1:0] CHAR_C = 8'h43;
    localparam logic [CHAR_W-1:0] CHAR_G = 8'h47;
    localparam logic [CHAR_W-1:0] CHAR_T = 8'h54;

    typedef enum logic {
        OP_LOAD  = 1'b0,
        OP_QUERY = 1'b1
    } t_op;

    typedef enum logic [ERR_W-1:0] {
        ERR_OK    = 3'd0,
        ERR_CHAR  = 3'd1,
        ERR_FULL  = 3'd2,
        ERR_START = 3'd3,
        ERR_ZERO  = 3'd4
    } t_err;

    // One classified item as it travels from the front to the back.
    typedef struct packed {
        t_op                 op;
        logic                restart;
        logic                char_ok;
        logic [BASE_W-1:0]   base;
        logic                q_zero;
        logic [QLEN_W-1:0]   qlen;
        logic [WORD_W-1:0]   query;
        logic [START_W-1:0]  start;
    } t_cmd;

endpackage

[rtl/pdpm_front.sv]
// Front end: accepts items, classifies them and queues them for the back end.
module pdpm_front (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_ready,
    input  logic                               i_mode,
    input  logic [pdpm_pkg::CHAR_W-1:0]        i_base_char,
    input  logic                               i_restart,
    input  logic [pdpm_pkg::WORD_W-1:0]        i_query_code,
    input  logic [pdpm_pkg::START_W-1:0]       i_start_index,
    output logic                               o_cmd_valid,
    input  logic                               i_cmd_ready,
    output pdpm_pkg::t_cmd                     o_cmd
);

    localparam int QD     = 2;
    localparam int QPTR_W = $clog2(QD);
    localparam int QCNT_W = $clog2(QD + 1);
    localparam int GROUPS = pdpm_pkg::WORD_W / pdpm_pkg::BASE_W;

    // Index of the highest nonzero base group, which equals the query length
    // once the sentinel base is discounted.
    function automatic logic [pdpm_pkg::QLEN_W-1:0] f_top_group(
        input logic [pdpm_pkg::WORD_W-1:0] code
    );
        logic [pdpm_pkg::QLEN_W-1:0] g;
        g = '0;
        for (int i = 0; i < GROUPS; i++) begin
            if (|code[pdpm_pkg::BASE_W*i +: pdpm_pkg::BASE_W]) begin
                g = pdpm_pkg::QLEN_W'(i);
            end
        end
        return g;
    endfunction

    pdpm_pkg::t_cmd      w_cmd;
    pdpm_pkg::t_cmd      r_q [QD];
    logic [QPTR_W-1:0]   r_wr_ptr;
    logic [QPTR_W-1:0]   n_wr_ptr;
    logic [QPTR_W-1:0]   r_rd_ptr;
    logic [QPTR_W-1:0]   n_rd_ptr;
    logic [QCNT_W-1:0]   r_count;
    logic [QCNT_W-1:0]   n_count;
    logic                w_push;
    logic                w_pop;

    always_comb begin
        w_cmd.op      = pdpm_pkg::t_op'(i_mode);
        w_cmd.restart = i_restart;
        w_cmd.char_ok = (i_base_char == pdpm_pkg::CHAR_A) || (i_base_char == pdpm_pkg::CHAR_C) ||
                        (i_base_char == pdpm_pkg::CHAR_G) || (i_base_char == pdpm_pkg::CHAR_T);
        w_cmd.base    = i_base_char[2:1];
        w_cmd.q_zero  = (i_query_code == '0);
        w_cmd.qlen    = f_top_group(i_query_code);
        w_cmd.query   = i_query_code;
        w_cmd.start   = i_start_index;
    end

    assign o_in_ready  = (r_count != QCNT_W'(QD));
    assign o_cmd_valid = (r_count != '0);
    assign o_cmd       = r_q[r_rd_ptr];
    assign w_push      = i_in_valid && o_in_ready;
    assign w_pop       = o_cmd_valid && i_cmd_ready;

    always_comb begin
        n_wr_ptr = w_push ? QPTR_W'(r_wr_ptr + 1'b1) : r_wr_ptr;
        n_rd_ptr = w_pop ? QPTR_W'(r_rd_ptr + 1'b1) : r_rd_ptr;
        n_count  = r_count;
        if (w_push && !w_pop) begin
            n_count = QCNT_W'(r_count + 1'b1);
        end else if (w_pop && !w_push) begin
            n_count = QCNT_W'(r_count - 1'b1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wr_ptr] <= w_cmd;
        end
    end

endmodule

[rtl/pdpm_back.sv]
// Back end: reference memory, load path, two-read query sequencer and result register.
module pdpm_back (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cmd_valid,
    output logic                               o_cmd_ready,
    input  pdpm_pkg::t_cmd                     i_cmd,
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output logic [pdpm_pkg::COUNT_W-1:0]       o_match_count,
    output logic [pdpm_pkg::ERR_W-1:0]         o_error
);

    localparam int GROUPS = pdpm_pkg::WORD_W / pdpm_pkg::BASE_W;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_RD1  = 4'b0010,
        S_CMP  = 4'b0100,
        S_RES  = 4'b1000
    } t_state;

    // Index of the lowest nonzero base group, or GROUPS when all are zero.
    function automatic logic [pdpm_pkg::GROUP_W-1:0] f_low_group(
        input logic [pdpm_pkg::WORD_W-1:0] v
    );
        logic [pdpm_pkg::GROUP_W-1:0] g;
        g = pdpm_pkg::GROUP_W'(GROUPS);
        for (int i = GROUPS - 1; i >= 0; i--) begin
            if (|v[pdpm_pkg::BASE_W*i +: pdpm_pkg::BASE_W]) begin
                g = pdpm_pkg::GROUP_W'(i);
            end
        end
        return g;
    endfunction

    t_state                             r_state;
    t_state                             n_state;
    logic [pdpm_pkg::LEN_W-1:0]         r_len;
    logic [pdpm_pkg::LEN_W-1:0]         n_len;
    logic [pdpm_pkg::WORD_W-1:0]        r_asm;
    logic [pdpm_pkg::WORD_W-1:0]        n_asm;
    logic                               r_out_valid;
    logic                               n_out_valid;
    logic [pdpm_pkg::COUNT_W-1:0]       r_match_count;
    logic [pdpm_pkg::COUNT_W-1:0]       n_match_count;
    pdpm_pkg::t_err                     r_error;
    pdpm_pkg::t_err                     n_error;
    logic [pdpm_pkg::COUNT_W-1:0]       r_rest;
    logic [pdpm_pkg::COUNT_W-1:0]       n_rest;
    logic [pdpm_pkg::QLEN_W-1:0]        r_qlen;
    logic [pdpm_pkg::QLEN_W-1:0]        n_qlen;
    logic [pdpm_pkg::WORD_W-1:0]        r_query;
    logic [pdpm_pkg::WORD_W-1:0]        n_query;
    logic [pdpm_pkg::OFF_W-1:0]         r_off;
    logic [pdpm_pkg::OFF_W-1:0]         n_off;
    logic [pdpm_pkg::WADDR_W-1:0]       r_w1;
    logic [pdpm_pkg::WADDR_W-1:0]       n_w1;
    logic [pdpm_pkg::WORD_W-1:0]        r_word0;
    logic [pdpm_pkg::WORD_W-1:0]        n_word0;
    logic [pdpm_pkg::WORD_W-1:0]        r_diff;
    logic [pdpm_pkg::WORD_W-1:0]        n_diff;

    logic [pdpm_pkg::WORD_W-1:0]        r_mem [pdpm_pkg::MAX_WORDS];
    logic [pdpm_pkg::WORD_W-1:0]        r_rd_data;
    logic                               mem_we;
    logic [pdpm_pkg::WADDR_W-1:0]       mem_waddr;
    logic [pdpm_pkg::WORD_W-1:0]        mem_wdata;
    logic                               mem_re;
    logic [pdpm_pkg::WADDR_W-1:0]       mem_raddr;

    logic                               out_free;
    logic [pdpm_pkg::LEN_W-1:0]         len_eff;
    logic [pdpm_pkg::WORD_W-1:0]        asm_eff;
    logic [pdpm_pkg::OFF_W-1:0]         ld_pos;
    logic [pdpm_pkg::WADDR_W-1:0]       ld_widx;
    logic [pdpm_pkg::WORD_W-1:0]        ld_asm;
    logic [pdpm_pkg::LEN_W-1:0]         q_start;
    logic                               q_past_end;
    logic [pdpm_pkg::LEN_W-1:0]         q_rest_full;
    logic [pdpm_pkg::COUNT_W-1:0]       q_rest;
    logic [pdpm_pkg::WADDR_W-1:0]       q_widx;
    logic [pdpm_pkg::WADDR_W-1:0]       q_widx_next;
    logic [2*pdpm_pkg::WORD_W-1:0]      cmp_shift;
    logic [pdpm_pkg::WORD_W-1:0]        cmp_mask;
    logic [pdpm_pkg::WORD_W-1:0]        cmp_ref;
    logic [pdpm_pkg::GROUP_W-1:0]       res_d;
    logic [pdpm_pkg::GROUP_W-1:0]       res_c0;
    logic [pdpm_pkg::GROUP_W-1:0]       res_c1;

    assign out_free      = !r_out_valid || i_out_ready;
    assign o_cmd_ready   = (r_state == S_IDLE) && out_free;
    assign o_out_valid   = r_out_valid;
    assign o_match_count = r_match_count;
    assign o_error       = r_error;

    // Load path: a restart empties the string before the base is looked at.
    assign len_eff = i_cmd.restart ? '0 : r_len;
    assign asm_eff = i_cmd.restart ? '0 : r_asm;
    assign ld_pos  = len_eff[pdpm_pkg::OFF_W-1:0];
    assign ld_widx = len_eff[pdpm_pkg::OFF_W +: pdpm_pkg::WADDR_W];
    assign ld_asm  = asm_eff | (pdpm_pkg::WORD_W'(i_cmd.base) << {ld_pos, 1'b0});

    // Query setup: window length is the remaining reference, capped.
    assign q_start     = pdpm_pkg::LEN_W'(i_cmd.start);
    assign q_past_end  = (32'(i_cmd.start) > 32'(r_len));
    assign q_rest_full = r_len - q_start;
    assign q_rest      = (q_rest_full > pdpm_pkg::LEN_W'(pdpm_pkg::MAX_QUERY_LEN)) ?
                         pdpm_pkg::COUNT_W'(pdpm_pkg::MAX_QUERY_LEN) :
                         q_rest_full[pdpm_pkg::COUNT_W-1:0];
    assign q_widx      = q_start[pdpm_pkg::OFF_W +: pdpm_pkg::WADDR_W];
    assign q_widx_next = (q_widx == pdpm_pkg::WADDR_W'(pdpm_pkg::MAX_WORDS - 1)) ?
                         '0 : pdpm_pkg::WADDR_W'(q_widx + 1'b1);

    // Window alignment: the two words are joined, shifted down to the start base,
    // cut to the window length and closed with a sentinel base.
    assign cmp_shift = {r_rd_data, r_word0} >> {r_off, 1'b0};
    assign cmp_mask  = ~({pdpm_pkg::WORD_W{1'b1}} << {r_rest, 1'b0});
    assign cmp_ref   = (cmp_shift[pdpm_pkg::WORD_W-1:0] & cmp_mask) |
                       (pdpm_pkg::WORD_W'(1) << {r_rest, 1'b0});

    // Prefix length: first differing base, capped by window and query length.
    assign res_d  = f_low_group(r_diff);
    assign res_c0 = ({1'b0, r_rest} < res_d) ? {1'b0, r_rest} : res_d;
    assign res_c1 = ({1'b0, r_qlen} < res_c0) ? {1'b0, r_qlen} : res_c0;

    always_comb begin
        n_state       = r_state;
        n_len         = r_len;
        n_asm         = r_asm;
        n_out_valid   = r_out_valid && !i_out_ready;
        n_match_count = r_match_count;
        n_error       = r_error;
        n_rest        = r_rest;
        n_qlen        = r_qlen;
        n_query       = r_query;
        n_off         = r_off;
        n_w1          = r_w1;
        n_word0       = r_word0;
        n_diff        = r_diff;
        mem_we        = 1'b0;
        mem_waddr     = ld_widx;
        mem_wdata     = ld_asm;
        mem_re        = 1'b0;
        mem_raddr     = q_widx;

        unique case (r_state)
            S_IDLE: begin
                if (i_cmd_valid && out_free) begin
                    unique case (i_cmd.op)
                        pdpm_pkg::OP_LOAD: begin
                            n_out_valid   = 1'b1;
                            n_match_count = '0;
                            n_len         = len_eff;
                            n_asm         = asm_eff;
                            if (!i_cmd.char_ok) begin
                                n_error = pdpm_pkg::ERR_CHAR;
                            end else if (len_eff == pdpm_pkg::LEN_W'(pdpm_pkg::MAX_BASES)) begin
                                n_error = pdpm_pkg::ERR_FULL;
                            end else begin
                                n_error = pdpm_pkg::ERR_OK;
                                mem_we  = 1'b1;
                                n_len   = pdpm_pkg::LEN_W'(len_eff + 1'b1);
                                n_asm   = (ld_pos == pdpm_pkg::OFF_W'(pdpm_pkg::BASES_PER_WORD - 1))
                                          ? '0 : ld_asm;
                            end
                        end
                        pdpm_pkg::OP_QUERY: begin
                            if (i_cmd.q_zero) begin
                                n_out_valid   = 1'b1;
                                n_match_count = '0;
                                n_error       = pdpm_pkg::ERR_ZERO;
                            end else if (q_past_end) begin
                                n_out_valid   = 1'b1;
                                n_match_count = '0;
                                n_error       = pdpm_pkg::ERR_START;
                            end else if (q_rest == '0) begin
                                n_out_valid   = 1'b1;
                                n_match_count = '0;
                                n_error       = pdpm_pkg::ERR_OK;
                            end else begin
                                mem_re  = 1'b1;
                                n_rest  = q_rest;
                                n_qlen  = i_cmd.qlen;
                                n_query = i_cmd.query;
                                n_off   = q_start[pdpm_pkg::OFF_W-1:0];
                                n_w1    = q_widx_next;
                                n_state = S_RD1;
                            end
                        end
                    endcase
                end
            end
            S_RD1: begin
                mem_re    = 1'b1;
                mem_raddr = r_w1;
                n_word0   = r_rd_data;
                n_state   = S_CMP;
            end
            S_CMP: begin
                n_diff  = cmp_ref ^ r_query;
                n_state = S_RES;
            end
            S_RES: begin
                if (out_free) begin
                    n_out_valid   = 1'b1;
                    n_match_count = res_c1[pdpm_pkg::COUNT_W-1:0];
                    n_error       = pdpm_pkg::ERR_OK;
                    n_state       = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_len       <= '0;
            r_asm       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_len       <= n_len;
            r_asm       <= n_asm;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_match_count <= n_match_count;
        r_error       <= n_error;
        r_rest        <= n_rest;
        r_qlen        <= n_qlen;
        r_query       <= n_query;
        r_off         <= n_off;
        r_w1          <= n_w1;
        r_word0       <= n_word0;
        r_diff        <= n_diff;
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            r_rd_data <= r_mem[mem_raddr];
        end
    end

endmodule

[rtl/packed_dna_prefix_match.sv]
// Top level of the packed DNA prefix match block: front end, queue and back end.
//
// Usage: every item arrives on the input channel (i_in_valid / o_in_ready) and
// produces exactly one result transfer on the output channel (o_out_valid /
// i_out_ready), in order. With i_mode low an item appends one base to the
// reference string, which is held two bits per base in a 2048 x 64 memory; with
// i_mode high it asks how many leading bases of i_query_code match the reference
// from i_start_index on.
// A load result is registered when the back end takes the command; a query
// passes through states S_RD1, S_CMP and S_RES and its result is registered on
// leaving S_RES, when the output is free. A two-entry queue sits between the front
// end and the back end, so input transfers continue while the back end is busy
// until the queue is full. Throughput: loads sustain one per cycle while the output
// is not stalled. A query holds the back end through S_RD1, S_CMP and S_RES: two
// reads of the single-read-port memory, then window alignment, then the prefix search.
// Reset (synchronous, active low) empties the queue, drops any pending result and
// sets the reference length and word assembly to zero; the memory is not cleared,
// because no query reads a base beyond the current length.
// When the receiver stalls, the result is held in the output register, the back
// end stops taking commands, and the queue then fills and drops o_in_ready.
`include "packed_dna_prefix_match_defines.svh"

module packed_dna_prefix_match (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_ready,
    input  logic                               i_mode,
    input  logic [pdpm_pkg::CHAR_W-1:0]        i_base_char,
    input  logic                               i_restart,
    input  logic [pdpm_pkg::WORD_W-1:0]        i_query_code,
    input  logic [pdpm_pkg::START_W-1:0]       i_start_index,
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output logic [pdpm_pkg::COUNT_W-1:0]       o_match_count,
    output logic [pdpm_pkg::ERR_W-1:0]         o_error
);

    logic           w_cmd_valid;
    logic           w_cmd_ready;
    pdpm_pkg::t_cmd w_cmd;

    // The front end classifies each item and buffers it until the back end is free.
    pdpm_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_mode        (i_mode),
        .i_base_char   (i_base_char),
        .i_restart     (i_restart),
        .i_query_code  (i_query_code),
        .i_start_index (i_start_index),
        .o_cmd_valid   (w_cmd_valid),
        .i_cmd_ready   (w_cmd_ready),
        .o_cmd         (w_cmd)
    );

    // The back end owns the reference state and produces the results.
    pdpm_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd_valid   (w_cmd_valid),
        .o_cmd_ready   (w_cmd_ready),
        .i_cmd         (w_cmd),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_match_count (o_match_count),
        .o_error       (o_error)
    );

    // An accepted item is visible to the back end in the following cycle.
    `PDPM_CHECK_NEXT(a_in_reaches_queue, i_in_valid && o_in_ready, w_cmd_valid)
    // The back end never takes a command while a stalled result would be overwritten.
    `PDPM_CHECK_NOW(a_no_result_overwrite, w_cmd_valid && w_cmd_ready, !o_out_valid || i_out_ready)
    // Every error result reports no matching bases.
    `PDPM_CHECK_NOW(a_error_zero_count, o_out_valid && (o_error != pdpm_pkg::ERR_OK), o_match_count == '0)

endmodule
